// File: rtl/core/dda_pkg.sv
package dda_pkg;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SETUP,
      ST_DIVIDE,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic load;       // capture endpoints, preset accumulators
      logic div_start;  // launch the minor-axis increment division
      logic set_inc;    // latch both increments; the minor one comes from the divider
      logic step;       // emit current pixel and advance
   } cmd_type;

   typedef struct packed {
      logic steps_zero;
      logic div_done;
      logic last;
   } status_type;

endpackage

// File: rtl/core/dda_div.sv
// Restoring divider, one quotient bit per cycle.
module dda_div #(
   parameter int DIVIDEND_BITS = 22,
   parameter int DIVISOR_BITS  = 6
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [DIVIDEND_BITS-1:0] dividend,
   input  logic [DIVISOR_BITS-1:0]  divisor,
   output logic                     done,
   output logic [DIVIDEND_BITS-1:0] quotient
);

   localparam int CNT_BITS = $clog2(DIVIDEND_BITS);

   logic [DIVISOR_BITS-1:0]  rem_ff, rem_in;
   logic [DIVIDEND_BITS-1:0] quo_ff, quo_in;
   logic [DIVISOR_BITS-1:0]  divisor_ff;
   logic [CNT_BITS-1:0]      cnt_ff;
   logic                     run_ff, done_ff;
   logic [DIVISOR_BITS:0]    shifted, diff;
   logic                     ge;

   assign shifted = {rem_ff, quo_ff[DIVIDEND_BITS-1]};
   assign diff    = shifted - {1'b0, divisor_ff};
   assign ge      = shifted >= {1'b0, divisor_ff};
   assign rem_in  = ge ? diff[DIVISOR_BITS-1:0] : shifted[DIVISOR_BITS-1:0];
   assign quo_in  = {quo_ff[DIVIDEND_BITS-2:0], ge};

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            run_ff <= 1'b1;
            cnt_ff <= '0;
         end else if (run_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CNT_BITS'(DIVIDEND_BITS - 1)) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff     <= '0;
         quo_ff     <= dividend;
         divisor_ff <= divisor;
      end else if (run_ff) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// File: rtl/core/dda_datapath.sv
module dda_datapath #(
   parameter int COORD_BITS = 6,
   parameter int FRAC_BITS  = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  dda_pkg::cmd_type       cmd,
   output dda_pkg::status_type    status,
   input  logic [COORD_BITS-1:0]  req_start_x,
   input  logic [COORD_BITS-1:0]  req_start_y,
   input  logic [COORD_BITS-1:0]  req_end_x,
   input  logic [COORD_BITS-1:0]  req_end_y,
   output logic [COORD_BITS-1:0]  pixel_x,
   output logic [COORD_BITS-1:0]  pixel_y
);

   localparam int ACC_BITS = COORD_BITS + FRAC_BITS;
   localparam logic [ACC_BITS-1:0] UNIT = ACC_BITS'(1) << FRAC_BITS;
   localparam logic [ACC_BITS:0]   HALF = (ACC_BITS + 1)'(1) << (FRAC_BITS - 1);

   logic [COORD_BITS-1:0] x0_ff, y0_ff, x1_ff, y1_ff;
   logic [ACC_BITS-1:0]   x_acc_ff, y_acc_ff, x_inc_ff, y_inc_ff;
   logic [COORD_BITS-1:0] cnt_ff;

   logic                  x_neg, y_neg, x_major;
   logic [COORD_BITS-1:0] adx, ady, steps, minor;
   logic [ACC_BITS-1:0]   dividend, quotient, minor_pos, minor_inc;
   logic [ACC_BITS:0]     x_round, y_round;
   logic                  div_done;

   assign x_neg   = x1_ff < x0_ff;
   assign y_neg   = y1_ff < y0_ff;
   assign adx     = x_neg ? (x0_ff - x1_ff) : (x1_ff - x0_ff);
   assign ady     = y_neg ? (y0_ff - y1_ff) : (y1_ff - y0_ff);
   assign x_major = adx > ady;
   assign steps   = x_major ? adx : ady;
   assign minor   = x_major ? ady : adx;
   assign dividend = {minor, {FRAC_BITS{1'b0}}};

   dda_div #(
      .DIVIDEND_BITS(ACC_BITS),
      .DIVISOR_BITS (COORD_BITS)
   ) u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (cmd.div_start),
      .dividend(dividend),
      .divisor (steps),
      .done    (div_done),
      .quotient(quotient)
   );

   assign minor_pos = quotient;
   assign minor_inc = (x_major ? y_neg : x_neg) ? (~minor_pos + 1'b1) : minor_pos;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         x0_ff    <= req_start_x;
         y0_ff    <= req_start_y;
         x1_ff    <= req_end_x;
         y1_ff    <= req_end_y;
         x_acc_ff <= {req_start_x, {FRAC_BITS{1'b0}}};
         y_acc_ff <= {req_start_y, {FRAC_BITS{1'b0}}};
         cnt_ff   <= '0;
      end else if (cmd.step) begin
         x_acc_ff <= x_acc_ff + x_inc_ff;
         y_acc_ff <= y_acc_ff + y_inc_ff;
         cnt_ff   <= cnt_ff + 1'b1;
      end
      if (cmd.set_inc) begin
         // major axis moves one whole pixel per step
         if (x_major) begin
            x_inc_ff <= x_neg ? (~UNIT + 1'b1) : UNIT;
            y_inc_ff <= minor_inc;
         end else begin
            x_inc_ff <= minor_inc;
            y_inc_ff <= y_neg ? (~UNIT + 1'b1) : UNIT;
         end
      end
   end

   assign x_round = {1'b0, x_acc_ff} + HALF;
   assign y_round = {1'b0, y_acc_ff} + HALF;
   assign pixel_x = x_round[ACC_BITS-1:FRAC_BITS];
   assign pixel_y = y_round[ACC_BITS-1:FRAC_BITS];

   assign status.steps_zero = steps == '0;
   assign status.div_done   = div_done;
   assign status.last       = cnt_ff == steps;

endmodule

// File: rtl/core/dda_ctrl.sv
module dda_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   output logic                rsp_valid,
   output logic                rsp_last_pixel,
   input  dda_pkg::status_type status,
   output dda_pkg::cmd_type    cmd
);

   dda_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dda_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in       = state_ff;
      cmd            = '0;
      busy           = 1'b1;
      rsp_valid      = 1'b0;
      rsp_last_pixel = 1'b0;
      case (state_ff)
         dda_pkg::ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.load = 1'b1;
               state_in = dda_pkg::ST_SETUP;
            end
         end
         dda_pkg::ST_SETUP: begin
            if (status.steps_zero) begin
               state_in = dda_pkg::ST_EMIT;
            end else begin
               cmd.div_start = 1'b1;
               state_in      = dda_pkg::ST_DIVIDE;
            end
         end
         dda_pkg::ST_DIVIDE: begin
            if (status.div_done) begin
               cmd.set_inc = 1'b1;
               state_in    = dda_pkg::ST_EMIT;
            end
         end
         dda_pkg::ST_EMIT: begin
            rsp_valid      = 1'b1;
            rsp_last_pixel = status.last;
            cmd.step       = 1'b1;
            if (status.last) begin
               state_in = dda_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = dda_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

// File: rtl/core/dda_line_rasterizer.sv
// DDA line rasterizer.
// Input: a segment (req_start_x/y, req_end_x/y) is taken at a clock edge
// where start is high and busy is low. busy stays high until the segment's
// last pixel has been sent.
// Output: one pixel per cycle on rsp_pixel_x/y, marked by rsp_valid, with
// rsp_last_pixel on the final one. The receiver cannot stall; each pixel is
// present for exactly one cycle.
// Sequence: a setup state, then the minor-axis increment is divided out by a
// bit-serial divider over COORD_BITS+FRAC_BITS quotient bits. Then come the
// pixels back to back, steps+1 pixels in all, where steps is the larger of
// the x and y spans. A zero-length segment skips the divider: its single
// pixel follows the setup state directly.
// Reset (synchronous) returns the controller to idle and drops any segment
// in progress.
module dda_line_rasterizer #(
   parameter int COORD_BITS = 6,
   parameter int FRAC_BITS  = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [COORD_BITS-1:0] req_start_x,
   input  logic [COORD_BITS-1:0] req_start_y,
   input  logic [COORD_BITS-1:0] req_end_x,
   input  logic [COORD_BITS-1:0] req_end_y,
   output logic                  rsp_valid,
   output logic [COORD_BITS-1:0] rsp_pixel_x,
   output logic [COORD_BITS-1:0] rsp_pixel_y,
   output logic                  rsp_last_pixel
);

   dda_pkg::cmd_type    cmd;
   dda_pkg::status_type status;

   dda_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .rsp_valid     (rsp_valid),
      .rsp_last_pixel(rsp_last_pixel),
      .status        (status),
      .cmd           (cmd)
   );

   dda_datapath #(
      .COORD_BITS(COORD_BITS),
      .FRAC_BITS (FRAC_BITS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_start_x(req_start_x),
      .req_start_y(req_start_y),
      .req_end_x  (req_end_x),
      .req_end_y  (req_end_y),
      .pixel_x    (rsp_pixel_x),
      .pixel_y    (rsp_pixel_y)
   );

`ifndef SYNTHESIS
   a_valid_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("pixel strobe outside a transaction");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy && !rsp_valid))
      else $error("accepted segment not held busy");

   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last_pixel) |=> (!busy && !rsp_valid))
      else $error("activity after last pixel");

   a_pixels_run: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last_pixel) |=> rsp_valid)
      else $error("gap inside pixel run");
`endif

endmodule

// File: sim/dda_line_rasterizer_tb.sv
module dda_line_rasterizer_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int COORD_BITS = 6;
   localparam int FRAC_BITS  = 16;
   localparam int ACC_BITS   = COORD_BITS + FRAC_BITS + 1;
   // setup + divider + longest pixel run, with a little margin
   localparam int SEGMENT_CYCLES = COORD_BITS + FRAC_BITS + 4 + (1 << COORD_BITS);
   localparam int CYCLE_LIMIT    = 200000;
   localparam int RANDOM_ITEMS   = 130;

   typedef logic [COORD_BITS-1:0] coord_type;
   typedef logic [ACC_BITS-1:0]   fixed_type;

   typedef struct packed {
      coord_type x;
      coord_type y;
      logic      last;
   } pixel_type;

   localparam fixed_type HALF_PIXEL = fixed_type'(1) << (FRAC_BITS - 1);

   logic      clock = 1'b0;
   logic      reset = 1'b1;
   logic      start = 1'b0;
   logic      busy;
   coord_type req_start_x = '0;
   coord_type req_start_y = '0;
   coord_type req_end_x   = '0;
   coord_type req_end_y   = '0;
   logic      rsp_valid;
   coord_type rsp_pixel_x;
   coord_type rsp_pixel_y;
   logic      rsp_last_pixel;

   pixel_type pending_pixels[$];
   int        error_count = 0;
   int        cycle_count = 0;

   dda_line_rasterizer #(
      .COORD_BITS(COORD_BITS),
      .FRAC_BITS (FRAC_BITS)
   ) i_dut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_start_x   (req_start_x),
      .req_start_y   (req_start_y),
      .req_end_x     (req_end_x),
      .req_end_y     (req_end_y),
      .rsp_valid     (rsp_valid),
      .rsp_pixel_x   (rsp_pixel_x),
      .rsp_pixel_y   (rsp_pixel_y),
      .rsp_last_pixel(rsp_last_pixel)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("%0t: timeout after %0d cycles", $time, cycle_count);
         $display("dda_line_rasterizer_tb: errors");
         $finish;
      end
   end

   // signed per-step increment, two's complement at accumulator width
   function automatic fixed_type axis_increment(coord_type from, coord_type to,
                                                coord_type steps);
      fixed_type mag;
      if (to >= from) begin
         mag = (fixed_type'(to - from) << FRAC_BITS) / fixed_type'(steps);
         return mag;
      end
      mag = (fixed_type'(from - to) << FRAC_BITS) / fixed_type'(steps);
      return -mag;
   endfunction

   function automatic void rasterize_segment(coord_type x0, coord_type y0,
                                             coord_type x1, coord_type y1);
      coord_type adx;
      coord_type ady;
      coord_type steps;
      fixed_type xinc;
      fixed_type yinc;
      fixed_type xacc;
      fixed_type yacc;
      pixel_type px;
      adx   = (x1 >= x0) ? x1 - x0 : x0 - x1;
      ady   = (y1 >= y0) ? y1 - y0 : y0 - y1;
      steps = (adx > ady) ? adx : ady;
      if (steps == 0) begin
         px = '{x: x0, y: y0, last: 1'b1};
         pending_pixels.push_back(px);
         return;
      end
      xinc = axis_increment(x0, x1, steps);
      yinc = axis_increment(y0, y1, steps);
      xacc = fixed_type'(x0) << FRAC_BITS;
      yacc = fixed_type'(y0) << FRAC_BITS;
      for (int k = 0; k <= steps; k++) begin
         px.x    = coord_type'((xacc + HALF_PIXEL) >> FRAC_BITS);
         px.y    = coord_type'((yacc + HALF_PIXEL) >> FRAC_BITS);
         px.last = (k == steps);
         pending_pixels.push_back(px);
         xacc = xacc + xinc;
         yacc = yacc + yinc;
      end
   endfunction

   always @(posedge clock) begin : check_pixels
      pixel_type want;
      if (!reset && rsp_valid) begin
         if (pending_pixels.size() == 0) begin
            $display("%0t: pixel with none expected: x=%0d y=%0d last=%0b",
                     $time, rsp_pixel_x, rsp_pixel_y, rsp_last_pixel);
            error_count++;
         end else begin
            want = pending_pixels.pop_front();
            if (rsp_pixel_x !== want.x) begin
               $display("%0t: pixel_x expected %0d actual %0d", $time, want.x, rsp_pixel_x);
               error_count++;
            end
            if (rsp_pixel_y !== want.y) begin
               $display("%0t: pixel_y expected %0d actual %0d", $time, want.y, rsp_pixel_y);
               error_count++;
            end
            if (rsp_last_pixel !== want.last) begin
               $display("%0t: last_pixel expected %0b actual %0b",
                        $time, want.last, rsp_last_pixel);
               error_count++;
            end
         end
      end
   end

   // start stays high on return so a following transaction can go back to back
   task automatic send_segment(input coord_type x0, input coord_type y0,
                               input coord_type x1, input coord_type y1);
      start       <= 1'b1;
      req_start_x <= x0;
      req_start_y <= y0;
      req_end_x   <= x1;
      req_end_y   <= y1;
      do @(posedge clock); while (busy !== 1'b0);
      rasterize_segment(x0, y0, x1, y1);
   endtask

   task automatic sender_gap(input int cycles);
      if (cycles > 0) begin
         start <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   task automatic wait_for_drain(input int settle);
      start <= 1'b0;
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   task automatic pick_segment(output coord_type x0, output coord_type y0,
                               output coord_type x1, output coord_type y1);
      int span;
      int a;
      int b;
      x0 = coord_type'($urandom);
      y0 = coord_type'($urandom);
      x1 = coord_type'($urandom);
      y1 = coord_type'($urandom);
      case ($urandom_range(0, 9))
         0: begin
            x1 = x0;
            y1 = y0;
         end
         1: y1 = y0;
         2: x1 = x0;
         3: begin
            // equal spans on both axes
            span = $urandom_range(0, 63);
            a = $urandom_range(0, 63 - span);
            b = $urandom_range(0, 63 - span);
            if ($urandom_range(0, 1)) begin
               x0 = coord_type'(a);
               x1 = coord_type'(a + span);
            end else begin
               x0 = coord_type'(a + span);
               x1 = coord_type'(a);
            end
            if ($urandom_range(0, 1)) begin
               y0 = coord_type'(b);
               y1 = coord_type'(b + span);
            end else begin
               y0 = coord_type'(b + span);
               y1 = coord_type'(b);
            end
         end
         4, 5: begin
            x1 = coord_type'($urandom_range(x0 > 4 ? x0 - 4 : 0, x0 < 59 ? x0 + 4 : 63));
            y1 = coord_type'($urandom_range(y0 > 4 ? y0 - 4 : 0, y0 < 59 ? y0 + 4 : 63));
         end
         default: ;
      endcase
   endtask

   task automatic test_directed();
      coord_type segs[18][4] = '{
         '{0, 0, 0, 0},      '{63, 63, 63, 63},  '{21, 42, 21, 42},
         '{0, 0, 63, 0},     '{63, 0, 0, 0},     '{0, 0, 0, 63},
         '{0, 63, 0, 0},     '{0, 0, 63, 63},    '{63, 63, 0, 0},
         '{63, 0, 0, 63},    '{0, 63, 63, 0},    '{0, 0, 63, 1},
         '{63, 62, 0, 63},   '{5, 0, 6, 63},     '{10, 40, 50, 3},
         '{42, 21, 21, 42},  '{0, 0, 63, 32},    '{1, 62, 32, 0}
      };
      foreach (segs[i]) begin
         send_segment(segs[i][0], segs[i][1], segs[i][2], segs[i][3]);
         sender_gap($urandom_range(0, 3));
      end
   endtask

   task automatic test_back_to_back();
      coord_type x0, y0, x1, y1;
      for (int i = 0; i < 10; i++) begin
         pick_segment(x0, y0, x1, y1);
         send_segment(x0, y0, x1, y1);
      end
   endtask

   task automatic test_drain_pause();
      coord_type x0, y0, x1, y1;
      for (int i = 0; i < 4; i++) begin
         pick_segment(x0, y0, x1, y1);
         send_segment(x0, y0, x1, y1);
      end
      wait_for_drain($urandom_range(1, 6));
      send_segment(7, 3, 7, 3);
      send_segment(3, 60, 60, 3);
   endtask

   task automatic test_random(input int items);
      coord_type x0, y0, x1, y1;
      int burst_left;
      burst_left = $urandom_range(1, 8);
      for (int i = 0; i < items; i++) begin
         pick_segment(x0, y0, x1, y1);
         send_segment(x0, y0, x1, y1);
         burst_left--;
         if (burst_left == 0) begin
            // some bursts run straight into the next one
            sender_gap($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 100));
            burst_left = $urandom_range(1, 8);
         end
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_back_to_back();
      test_drain_pause();
      test_random(RANDOM_ITEMS);
      wait_for_drain(SEGMENT_CYCLES);
      if (error_count == 0) begin
         $display("dda_line_rasterizer_tb: clean");
      end else begin
         $display("dda_line_rasterizer_tb: errors");
      end
      $finish;
   end

endmodule

// File: filelist.f
rtl/core/dda_pkg.sv
rtl/core/dda_div.sv
rtl/core/dda_datapath.sv
rtl/core/dda_ctrl.sv
rtl/core/dda_line_rasterizer.sv
sim/dda_line_rasterizer_tb.sv
